### hdl/vgm_register_write_dedup_encoder_defines.svh
// Assertion macros for the VGM command stream encoder.
// Used by the top level only; no other dependencies.
`ifndef VGM_REGISTER_WRITE_DEDUP_ENCODER_DEFINES_SVH
`define VGM_REGISTER_WRITE_DEDUP_ENCODER_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define VGM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante implies cons");

// Next-cycle implication, disabled while reset is asserted.
`define VGM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante implies cons one cycle later");

`else

`define VGM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define VGM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/vgm_enc_pkg.sv
// Shared types and constants of the VGM command stream encoder.
// No dependencies; used by the emitter and the top level.
package vgm_enc_pkg;

    localparam int REGS_PER_BANK = 256;

    // Command bytes of the VGM stream.
    localparam logic [7:0] CMD_WRITE_BANK0 = 8'h5E;
    localparam logic [7:0] CMD_WRITE_BANKN = 8'h5F;
    localparam logic [7:0] CMD_WAIT        = 8'h61;
    localparam logic [7:0] CMD_END         = 8'h66;

    localparam logic [15:0] WAIT_RESET = 16'd735;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_WAIT  = 2'd1,
        ACT_END   = 2'd2
    } action_t;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } clr_state_t;

    // One shadow table entry: written flag and last value.
    typedef struct packed {
        logic       written;
        logic [7:0] value;
    } shadow_entry_t;

    // Load of one command (one to three bytes) into the output emitter.
    typedef struct packed {
        logic            valid;
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
        logic [31:0]     total;
    } emit_load_t;

endpackage

### hdl/vgm_enc_emitter.sv
// Output byte emitter: holds one command of up to three bytes and sends them in order.
// Depends on vgm_enc_pkg.
module vgm_enc_emitter
    import vgm_enc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  emit_load_t  load,
    output logic        load_ready,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last_byte,
    output logic [31:0] total_samples
);

    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;
    logic [2:0][7:0] bytes_reg;
    logic [2:0][7:0] bytes_next;
    logic [31:0]     total_reg;
    logic [31:0]     total_next;
    logic            pop;

    assign out_valid     = (cnt_reg != 2'd0);
    assign pop           = out_valid && !out_stall;
    assign load_ready    = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && !out_stall);
    assign out_byte      = bytes_reg[0];
    assign last_byte     = (cnt_reg == 2'd1);
    assign total_samples = total_reg;

    always_comb
    begin
        cnt_next   = cnt_reg;
        bytes_next = bytes_reg;
        total_next = total_reg;
        if (load.valid)
        begin
            cnt_next   = load.count;
            bytes_next = load.bytes;
            total_next = load.total;
        end
        else if (pop)
        begin
            cnt_next   = cnt_reg - 2'd1;
            bytes_next = {8'h00, bytes_reg[2], bytes_reg[1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        total_reg <= total_next;
    end

endmodule

### hdl/vgm_register_write_dedup_encoder.sv
// Flow: an accepted item is registered in the decision stage, which hands its command bytes
// to the emitter once the emitter is free; the emitter then sends them one byte at a time.
// Register writes and frame waits send three bytes each, bounded by the byte-wide output; end
// marks send one byte and suppressed writes none. The decision stage takes the next item while
// the emitter still sends the previous command. Reset: after rst_n releases, a clearing pass
// writes every shadow entry to "never written", during which no item is accepted.
`include "vgm_register_write_dedup_encoder_defines.svh"
module vgm_register_write_dedup_encoder
    import vgm_enc_pkg::*;
#(
    parameter int NUM_BANKS = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: wait count per frame.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] wait_samples_per_frame,
    // Input items.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic        bank,
    input  logic [7:0]  reg_addr,
    input  logic [7:0]  reg_value,
    // Output bytes.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last_byte,
    output logic [31:0] total_samples
);

    // The shadow table covers NUM_BANKS banks of 256 registers. The address is the bank
    // number above the register address, sized to the table depth.
    localparam int DEPTH = NUM_BANKS * REGS_PER_BANK;
    localparam int AW    = $clog2(DEPTH);

    // ------------------------------------------------------------------
    // Configuration register. The port is always ready; software must make sure it writes
    // it only while the encoder is idle, which the block itself does not enforce.
    // ------------------------------------------------------------------
    logic [15:0] wait_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg <= WAIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            wait_reg <= wait_samples_per_frame;
        end
    end

    // ------------------------------------------------------------------
    // Clearing pass after reset. The table is too large for a valid bit per
    // entry, so every entry is written to zero (never written) one per cycle.
    // ------------------------------------------------------------------
    clr_state_t    state_reg;
    clr_state_t    state_next;
    logic [AW-1:0] clr_ctr_reg;
    logic [AW-1:0] clr_ctr_next;
    logic          clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_ctr_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_ctr_reg <= clr_ctr_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_ctr_next = clr_ctr_reg;
        clearing     = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clearing     = 1'b1;
                clr_ctr_next = clr_ctr_reg + 1'b1;
                if (clr_ctr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                clearing = 1'b0;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 0: an accepted transaction issues a shadow table read. The read
    // data arrives in the decision stage on the next cycle.
    // ------------------------------------------------------------------
    logic          in_accept;
    logic [AW-1:0] in_addr;

    assign in_accept = in_valid && !in_stall;
    assign in_addr   = AW'({bank, reg_addr});

    // Decision stage registers.
    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic [1:0]    s1_action_reg;
    logic          s1_bank_reg;
    logic          s1_bank_ok_reg;
    logic [7:0]    s1_addr_reg;
    logic [7:0]    s1_value_reg;
    shadow_entry_t rd_data_reg;

    // Last write to the table, used to forward a write that lands on the
    // same edge at which the following transaction reads the same entry.
    logic          lw_valid_reg;
    logic [AW-1:0] lw_addr_reg;
    shadow_entry_t lw_data_reg;

    // Shadow table memory and its write port.
    shadow_entry_t shadow_mem [DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    shadow_entry_t mem_wdata;

    // ------------------------------------------------------------------
    // Decision stage: compare against the shadow entry, write it back, update
    // the sample total and hand the command bytes to the emitter.
    // ------------------------------------------------------------------
    logic [AW-1:0] s1_mem_addr;
    shadow_entry_t s1_entry;
    logic          is_write;
    logic          is_wait;
    logic          is_end;
    logic          wr_emit;
    logic          has_result;
    logic          s1_fire;
    logic          load_ready;
    emit_load_t    load;
    logic [31:0]   total_reg;
    logic [31:0]   total_next;
    logic [31:0]   total_sum;

    assign s1_mem_addr = AW'({s1_bank_reg, s1_addr_reg});
    assign s1_entry    = (lw_valid_reg && (lw_addr_reg == s1_mem_addr)) ? lw_data_reg
                                                                         : rd_data_reg;

    // Action code 3 matches none of these and passes through without a result.
    assign is_write   = (s1_action_reg == ACT_WRITE) && s1_bank_ok_reg;
    assign is_wait    = (s1_action_reg == ACT_WAIT);
    assign is_end     = (s1_action_reg == ACT_END);
    assign wr_emit    = is_write && !(s1_entry.written && (s1_entry.value == s1_value_reg));
    assign has_result = wr_emit || is_wait || is_end;

    // An item without a result leaves at once; otherwise it waits for the emitter.
    assign s1_fire   = s1_valid_reg && (!has_result || load_ready);
    assign total_sum = total_reg + {16'h0000, wait_reg};

    always_comb
    begin
        total_next = total_reg;
        if (s1_fire && is_wait)
        begin
            total_next = total_sum;
        end
    end

    always_comb
    begin
        load.valid = s1_fire && has_result;
        load.count = 2'd3;
        load.bytes = {s1_value_reg, s1_addr_reg,
                      s1_bank_reg ? CMD_WRITE_BANKN : CMD_WRITE_BANK0};
        load.total = total_next;
        if (is_wait)
        begin
            load.bytes = {wait_reg[15:8], wait_reg[7:0], CMD_WAIT};
        end
        else if (is_end)
        begin
            load.count = 2'd1;
            load.bytes = {8'h00, 8'h00, CMD_END};
        end
    end

    // The next transaction enters while this one is still being decided, unless
    // the decision stage is held by a busy emitter or the clearing pass is running.
    assign in_stall      = clearing || (s1_valid_reg && !s1_fire);
    assign s1_valid_next = in_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
            total_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            total_reg    <= total_next;
            if (s1_fire && wr_emit)
            begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_action_reg  <= action;
            s1_bank_reg    <= bank;
            s1_bank_ok_reg <= (NUM_BANKS > 1) || !bank;
            s1_addr_reg    <= reg_addr;
            s1_value_reg   <= reg_value;
        end
        if (s1_fire && wr_emit)
        begin
            lw_addr_reg <= s1_mem_addr;
            lw_data_reg <= mem_wdata;
        end
    end

    // Memory write port: the clearing pass, then the decision stage.
    always_comb
    begin
        if (clearing)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_ctr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we            = s1_fire && wr_emit;
            mem_waddr         = s1_mem_addr;
            mem_wdata.written = 1'b1;
            mem_wdata.value   = s1_value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            shadow_mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept)
        begin
            rd_data_reg <= shadow_mem[in_addr];
        end
    end

    // ------------------------------------------------------------------
    // Output emitter: one command buffered, reloaded when empty or as its last byte leaves.
    // ------------------------------------------------------------------
    vgm_enc_emitter u_emitter
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .load_ready    (load_ready),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .last_byte     (last_byte),
        .total_samples (total_samples)
    );

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // No byte can be pending while the table is still being cleared.
    `VGM_ASSERT_IMPLIES(a_quiet_while_clearing, clk, rst_n, clearing, !out_valid && !s1_valid_reg)
    // A frame wait adds exactly the configured count to the running total.
    `VGM_ASSERT_NEXT(a_wait_adds_count, clk, rst_n, s1_fire && is_wait, total_reg == 32'($past(total_reg) + {16'h0000, $past(wait_reg)}))
    // An emitted register write starts with a bank write command byte.
    `VGM_ASSERT_NEXT(a_write_cmd_first, clk, rst_n, s1_fire && wr_emit, out_valid && (out_byte == CMD_WRITE_BANK0 || out_byte == CMD_WRITE_BANKN))

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the VGM register write dedup encoder.
// Depends on vgm_enc_pkg and the vgm_register_write_dedup_encoder RTL.
module tb;
    import vgm_enc_pkg::*;

    // The action port is two bits wide, and the package names only three codes.
    // The fourth code must be ignored by the block, so it gets a name here.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Cycles with no transaction on any channel before the run is declared hung.
    // This covers the clearing pass after reset and long random stalls.
    localparam int WATCHDOG_LIMIT = 4000;

    // Quiet cycles after the last expected byte. Suppressed writes and ignored
    // actions produce no byte, so this covers their way through the pipeline.
    localparam int SETTLE_CYCLES = 8;

    // Input transactions in each random phase.
    localparam int RANDOM_ITEMS_PER_PHASE = 113;

    // One expected byte of the command stream.
    typedef struct packed {
        logic [7:0]  cmd_byte;
        logic        last;
        logic [31:0] total;
    } cmd_byte_t;

    // Predicts the command stream from the accepted transactions and checks the
    // bytes that leave the block against that prediction, in order.
    class vgm_stream_scoreboard;
        logic [8:0]  shadow [512];   // bit 8 means written, bits 7..0 hold the value
        logic [31:0] sample_total;
        logic [15:0] wait_count;
        cmd_byte_t   pending [$];
        int          errors;
        int          bytes_checked;
        int          items_with_results;
        int          writes_emitted;
        int          writes_suppressed;
        int          waits_seen;
        int          ends_seen;
        int          ignored_seen;
        int          settings_seen;

        function new();
            foreach (shadow[i])
                shadow[i] = 9'd0;
            sample_total = 32'd0;
            wait_count = WAIT_RESET;
            errors = 0;
            bytes_checked = 0;
            items_with_results = 0;
            writes_emitted = 0;
            writes_suppressed = 0;
            waits_seen = 0;
            ends_seen = 0;
            ignored_seen = 0;
            settings_seen = 1;
        endfunction

        function void set_wait_count(logic [15:0] w);
            wait_count = w;
            settings_seen++;
        endfunction

        function void push_byte(logic [7:0] b, logic last);
            cmd_byte_t e;
            e.cmd_byte = b;
            e.last = last;
            e.total = sample_total;
            pending = {pending, e};
        endfunction

        // Notes one accepted input transaction and queues the bytes it causes.
        function void note_item(logic [1:0] act, logic b, logic [7:0] a, logic [7:0] v);
            logic [8:0] idx;
            logic [8:0] entry;
            idx = {b, a};
            case (act)
                ACT_WRITE:
                begin
                    entry = shadow[idx];
                    if (entry[8] && entry[7:0] == v)
                    begin
                        writes_suppressed++;
                    end
                    else
                    begin
                        shadow[idx] = {1'b1, v};
                        push_byte(b ? CMD_WRITE_BANKN : CMD_WRITE_BANK0, 1'b0);
                        push_byte(a, 1'b0);
                        push_byte(v, 1'b1);
                        writes_emitted++;
                        items_with_results++;
                    end
                end
                ACT_WAIT:
                begin
                    sample_total = sample_total + {16'd0, wait_count};
                    push_byte(CMD_WAIT, 1'b0);
                    push_byte(wait_count[7:0], 1'b0);
                    push_byte(wait_count[15:8], 1'b1);
                    waits_seen++;
                    items_with_results++;
                end
                ACT_END:
                begin
                    push_byte(CMD_END, 1'b1);
                    ends_seen++;
                    items_with_results++;
                end
                default:
                begin
                    ignored_seen++;
                end
            endcase
        endfunction

        // Compares one accepted output byte with the oldest expectation.
        function void check_byte(logic [7:0] ob, logic lb, logic [31:0] ts);
            cmd_byte_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected byte: expected none, actual out_byte=%02h last=%0b total=%0d",
                         $time, ob, lb, ts);
                errors++;
                return;
            end
            e = pending.pop_front();
            bytes_checked++;
            if (ob !== e.cmd_byte)
            begin
                $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                         $time, e.cmd_byte, ob);
                errors++;
            end
            if (lb !== e.last)
            begin
                $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                         $time, e.last, lb);
                errors++;
            end
            if (ts !== e.total)
            begin
                $display("%0t: total_samples mismatch: expected %0d, actual %0d",
                         $time, e.total, ts);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] wait_samples_per_frame = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  action = 2'd0;
    logic        bank = 1'b0;
    logic [7:0]  reg_addr = 8'd0;
    logic [7:0]  reg_value = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        last_byte;
    logic [31:0] total_samples;

    // Percent of cycles in which the sender holds back or the receiver stalls.
    int send_idle = 37;
    int recv_idle = 83;
    int idle_cycles = 0;

    vgm_stream_scoreboard sb = new();

    vgm_register_write_dedup_encoder dut (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .wait_samples_per_frame (wait_samples_per_frame),
        .in_valid               (in_valid),
        .in_stall               (in_stall),
        .action                 (action),
        .bank                   (bank),
        .reg_addr               (reg_addr),
        .reg_value              (reg_value),
        .out_valid              (out_valid),
        .out_stall              (out_stall),
        .out_byte               (out_byte),
        .last_byte              (last_byte),
        .total_samples          (total_samples)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The receiver stalls at random according to the current idle rate.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle);
    end

    // Monitor. All three channels are sampled at the same edge in one process.
    // The configuration comes first so that a later wait uses the new count, and
    // inputs are noted before outputs are checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_wait_count(wait_samples_per_frame);
            if (in_valid && !in_stall)
                sb.note_item(action, bank, reg_addr, reg_value);
            if (out_valid && !out_stall)
                sb.check_byte(out_byte, last_byte, total_samples);
        end
    end

    // Watchdog. It counts cycles in which no transaction completes on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Writes the wait count per frame. It is called at a rising edge while the
    // block is idle, and it returns at the edge where the write completes.
    task automatic write_wait_count(input logic [15:0] w);
        cfg_valid <= 1'b1;
        wait_samples_per_frame <= w;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Presents one input transaction after a random gap and returns at the edge
    // where it is accepted. The payload is held steady while the block stalls.
    task automatic send_item(input logic [1:0] act, input logic b,
                             input logic [7:0] a, input logic [7:0] v);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        bank <= b;
        reg_addr <= a;
        reg_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Most random traffic is register writes to a small cluster of addresses with
    // a few common values, so repeated values occur often and get suppressed. The
    // rest is frame waits, end marks, and the unused action code. The fields that
    // a wait or an end mark ignores carry random junk.
    task automatic send_random_item();
        logic [1:0] act;
        logic       b;
        logic [7:0] a;
        logic [7:0] v;
        int         pick;
        pick = $urandom_range(0, 99);
        b = 1'($urandom_range(0, 1));
        a = 8'($urandom);
        v = 8'($urandom);
        if (pick < 70)
        begin
            act = ACT_WRITE;
            if ($urandom_range(0, 99) < 60)
                a = 8'hB0 + 8'($urandom_range(0, 7));
            if ($urandom_range(0, 99) < 50)
                v = 8'($urandom_range(0, 3));
        end
        else if (pick < 85)
            act = ACT_WAIT;
        else if (pick < 93)
            act = ACT_END;
        else
            act = ACT_UNUSED;
        send_item(act, b, a, v);
    endtask

    // Waits until every expected byte has arrived, then lets the pipeline settle
    // so that no suppressed or ignored transaction is still in flight.
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random_phase(input int s_idle, input int r_idle, input logic [15:0] w);
        send_idle = s_idle;
        recv_idle = r_idle;
        write_wait_count(w);
        repeat (RANDOM_ITEMS_PER_PHASE)
            send_random_item();
        drain_and_settle();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first with the wait count from reset. It covers a first
        // write of value zero, a repeated value, both banks at the extreme
        // addresses and values, bank separation at one address, junk in the
        // unused fields of a wait and an end mark, the unused action code, and
        // writes after an end mark.
        send_item(ACT_WRITE,  1'b0, 8'h00, 8'h00);
        send_item(ACT_WRITE,  1'b0, 8'h00, 8'h00);
        send_item(ACT_WRITE,  1'b0, 8'h00, 8'hFF);
        send_item(ACT_WRITE,  1'b1, 8'hFF, 8'hFF);
        send_item(ACT_WRITE,  1'b1, 8'hFF, 8'hFF);
        send_item(ACT_WRITE,  1'b1, 8'hFF, 8'h00);
        send_item(ACT_WRITE,  1'b1, 8'h00, 8'h00);
        send_item(ACT_WRITE,  1'b0, 8'hFF, 8'h00);
        send_item(ACT_WAIT,   1'b1, 8'hFF, 8'hFF);
        send_item(ACT_UNUSED, 1'b1, 8'h5A, 8'hA5);
        send_item(ACT_END,    1'b1, 8'hA5, 8'h5A);
        send_item(ACT_WRITE,  1'b0, 8'h00, 8'hFF);
        send_item(ACT_WRITE,  1'b0, 8'h00, 8'h55);
        send_item(ACT_WAIT,   1'b0, 8'h00, 8'h00);
        drain_and_settle();

        // A zero wait count is emitted as given and leaves the total unchanged.
        write_wait_count(16'd0);
        send_item(ACT_WAIT,   1'b0, 8'h00, 8'h00);
        send_item(ACT_WRITE,  1'b1, 8'h80, 8'h7F);
        send_item(ACT_WAIT,   1'b1, 8'hFF, 8'hFF);
        drain_and_settle();

        // Largest wait count.
        write_wait_count(16'hFFFF);
        send_item(ACT_WAIT,   1'b0, 8'h00, 8'h00);
        send_item(ACT_WAIT,   1'b1, 8'h01, 8'h80);
        send_item(ACT_END,    1'b0, 8'h00, 8'h00);
        send_item(ACT_UNUSED, 1'b0, 8'h00, 8'h00);
        drain_and_settle();

        // Random part. The sender's idle rate and the receiver's stall rate are
        // swapped between the first two phases, and the last phase runs without
        // idling. Each phase starts with a new wait count.
        run_random_phase(37, 83, 16'd1);
        run_random_phase(83, 37, 16'($urandom_range(0, 65535)));
        run_random_phase(0, 0, 16'($urandom_range(1, 65535)));

        $display("tb: %0d writes emitted, %0d suppressed, %0d waits, %0d end marks, %0d ignored",
                 sb.writes_emitted, sb.writes_suppressed, sb.waits_seen, sb.ends_seen,
                 sb.ignored_seen);
        $display("tb: %0d command bytes from %0d transactions checked over %0d wait counts, %0d mismatches",
                 sb.bytes_checked, sb.items_with_results, sb.settings_seen, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
